FILE: src/bsfp_pkg.sv
// bsfp_pkg: shared types and constants of the byte-stuffed frame parser
// used by the channel interfaces, the byte decoder and the core top level
`timescale 1ns / 1ps
`default_nettype none

package bsfp_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned CNT_W       = 5;   // holds frame length plus one, up to 17
   localparam int unsigned FULL_PAYLOAD = 13;
   localparam int unsigned PAY_HI_BYTES = 8;
   localparam int unsigned PAY_LO_BYTES = FULL_PAYLOAD - PAY_HI_BYTES;
   localparam int unsigned PAY_HI_W    = PAY_HI_BYTES * BYTE_W;
   localparam int unsigned PAY_LO_W    = PAY_LO_BYTES * BYTE_W;
   localparam int unsigned CHECK_W     = 2 * BYTE_W;

   localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
   localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
   localparam logic [BYTE_W-1:0] ESC_XOR   = 8'h20;

   typedef struct packed {
      logic             opening_seen;
      logic             escape_pending;
      logic             frame_closed;
      logic [CNT_W-1:0] byte_count;
   } parse_state_type;

   typedef struct packed {
      logic              en;
      logic [BYTE_W-1:0] data;
   } store_wr_type;

endpackage

`default_nettype wire

FILE: src/bsfp_if.sv
// bsfp_req_if / bsfp_rsp_if: valid-ready channels of the frame parser
// depends on bsfp_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface bsfp_req_if
   import bsfp_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] raw_byte;
   logic              end_of_buffer;

   modport source (output valid, output raw_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input raw_byte, input end_of_buffer, output ready);
endinterface

interface bsfp_rsp_if
   import bsfp_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                frame_ok;
   logic [BYTE_W-1:0]   ctrl_byte;
   logic [PAY_HI_W-1:0] payload_high;
   logic [PAY_LO_W-1:0] payload_low;
   logic [CHECK_W-1:0]  check_word;

   modport source (output valid, output frame_ok, output ctrl_byte, output payload_high,
                   output payload_low, output check_word, input ready);
   modport sink   (input valid, input frame_ok, input ctrl_byte, input payload_high,
                   input payload_low, input check_word, output ready);
endinterface

`default_nettype wire

FILE: src/bsfp_decode.sv
// bsfp_decode: per-byte unstuffing decision, next parser state and store write
// depends on bsfp_pkg
`timescale 1ns / 1ps
`default_nettype none

module bsfp_decode
   import bsfp_pkg::*;
#(
   parameter int unsigned PAYLOAD_BYTES = 13
) (
   input  parse_state_type   cur_state,
   input  logic [BYTE_W-1:0] raw_byte,
   input  logic              last_byte,
   output parse_state_type   nxt_state,
   output store_wr_type      store_wr
);

   localparam logic [CNT_W-1:0] FRAME_LEN = CNT_W'(PAYLOAD_BYTES + 3);
   localparam logic [CNT_W-1:0] CNT_SAT   = CNT_W'(PAYLOAD_BYTES + 4);

   logic              collect;
   logic [BYTE_W-1:0] coll_byte;

   always_comb begin
      nxt_state = cur_state;
      collect   = 1'b0;
      coll_byte = raw_byte;
      if (!cur_state.frame_closed) begin
         if (cur_state.escape_pending) begin
            nxt_state.escape_pending = 1'b0;
            collect   = 1'b1;
            coll_byte = raw_byte ^ ESC_XOR;
         end else if (raw_byte == FLAG_BYTE) begin
            if (!cur_state.opening_seen) begin
               nxt_state.opening_seen = 1'b1;
            end else begin
               nxt_state.frame_closed = 1'b1;
            end
         end else if (raw_byte == ESC_BYTE && !last_byte) begin
            nxt_state.escape_pending = 1'b1;
         end else begin
            collect = 1'b1;
         end
      end
      // count saturates one past the frame length
      if (collect && cur_state.byte_count < CNT_SAT) begin
         nxt_state.byte_count = cur_state.byte_count + CNT_W'(1);
      end
      store_wr.en   = collect && (cur_state.byte_count < FRAME_LEN);
      store_wr.data = coll_byte;
   end

endmodule

`default_nettype wire

FILE: src/byte_stuffed_frame_parser_core.sv
// byte_stuffed_frame_parser_core: top level of the byte-stuffed frame parser
// depends on bsfp_pkg, bsfp_if (request and response channels) and bsfp_decode
`timescale 1ns / 1ps
`default_nettype none

// takes one raw byte per beat on req_chan and removes the byte stuffing: the
// first 0x7E flag of a buffer is dropped, a later unescaped flag closes the
// frame and the rest of the buffer is ignored, 0x7D makes the next byte be
// stored xor 0x20 (an escape in the final byte is kept as is). bytes ahead of
// the first flag are collected too. the beat with end_of_buffer set yields
// one rsp_chan beat: frame_ok plus control byte, payload and big-endian check
// word when exactly PAYLOAD_BYTES+3 bytes were collected, all zero otherwise;
// then the parser returns to its reset state. throughput is one byte per
// cycle while req_chan is not stalled; the last byte passes through the input
// register, then the result register holds the rsp_chan beat. req_chan stalls
// only while a final byte waits behind a result that rsp_chan has not taken
// yet. the check word is passed on unverified.
module byte_stuffed_frame_parser_core
   import bsfp_pkg::*;
#(
   parameter int unsigned PAYLOAD_BYTES = 13
) (
   input  wire         clock,
   input  wire         reset,
   bsfp_req_if.sink    req_chan,
   bsfp_rsp_if.source  rsp_chan
);

   localparam int unsigned     FRAME_LEN = PAYLOAD_BYTES + 3;
   localparam int unsigned     IDX_W     = $clog2(FRAME_LEN);
   localparam logic [CNT_W-1:0] FRAME_LEN_C = CNT_W'(FRAME_LEN);

   // input register stage
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;

   // parser control state and collected bytes
   parse_state_type   state_ff, state_in;
   store_wr_type      store_wr;
   logic [BYTE_W-1:0] store_ff [FRAME_LEN];
   logic [BYTE_W-1:0] view     [FRAME_LEN];

   // result register
   logic                rsp_valid_ff;
   logic                rsp_ok_ff,   rsp_ok_in;
   logic [BYTE_W-1:0]   rsp_ctrl_ff, rsp_ctrl_in;
   logic [PAY_HI_W-1:0] rsp_hi_ff,   rsp_hi_in;
   logic [PAY_LO_W-1:0] rsp_lo_ff,   rsp_lo_in;
   logic [CHECK_W-1:0]  rsp_chk_ff,  rsp_chk_in;

   logic out_free;
   logic go;
   logic frame_ok;
   logic [IDX_W-1:0] wr_idx;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   // a non-final byte never needs the result register
   assign go       = in_valid_ff && (!in_last_ff || out_free);
   assign req_chan.ready = !in_valid_ff || go;

   assign wr_idx = state_ff.byte_count[IDX_W-1:0];

   bsfp_decode #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_decode (
      .cur_state (state_ff),
      .raw_byte  (in_byte_ff),
      .last_byte (in_last_ff),
      .nxt_state (state_in),
      .store_wr  (store_wr)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.raw_byte;
         in_last_ff <= req_chan.end_of_buffer;
      end
   end

   // parser state, cleared after every final byte
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (go) begin
         if (in_last_ff) begin
            state_ff <= '0;
         end else begin
            state_ff <= state_in;
         end
      end
   end

   // byte store, written at the current count
   always_ff @(posedge clock) begin
      if (go && store_wr.en) begin
         store_ff[wr_idx] <= store_wr.data;
      end
   end

   // store contents including the byte taken this cycle
   always_comb begin
      for (int i = 0; i < FRAME_LEN; i++) begin
         view[i] = (store_wr.en && wr_idx == IDX_W'(i)) ? store_wr.data : store_ff[i];
      end
   end

   assign frame_ok = (state_in.byte_count == FRAME_LEN_C);

   // pack the result: payload big-endian, missing payload positions zero
   generate
      for (genvar k = 0; k < PAY_HI_BYTES; k++) begin : g_hi
         if (k < PAYLOAD_BYTES) begin : g_used
            assign rsp_hi_in[PAY_HI_W-1-k*BYTE_W -: BYTE_W] =
               frame_ok ? view[1+k] : '0;
         end else begin : g_zero
            assign rsp_hi_in[PAY_HI_W-1-k*BYTE_W -: BYTE_W] = '0;
         end
      end
      for (genvar k = 0; k < PAY_LO_BYTES; k++) begin : g_lo
         if (k + PAY_HI_BYTES < PAYLOAD_BYTES) begin : g_used
            assign rsp_lo_in[PAY_LO_W-1-k*BYTE_W -: BYTE_W] =
               frame_ok ? view[1+PAY_HI_BYTES+k] : '0;
         end else begin : g_zero
            assign rsp_lo_in[PAY_LO_W-1-k*BYTE_W -: BYTE_W] = '0;
         end
      end
   endgenerate

   assign rsp_ok_in   = frame_ok;
   assign rsp_ctrl_in = frame_ok ? view[0] : '0;
   assign rsp_chk_in  = frame_ok ? {view[PAYLOAD_BYTES+1], view[PAYLOAD_BYTES+2]} : '0;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (go && in_last_ff) begin
         rsp_ok_ff   <= rsp_ok_in;
         rsp_ctrl_ff <= rsp_ctrl_in;
         rsp_hi_ff   <= rsp_hi_in;
         rsp_lo_ff   <= rsp_lo_in;
         rsp_chk_ff  <= rsp_chk_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.frame_ok     = rsp_ok_ff;
   assign rsp_chan.ctrl_byte    = rsp_ctrl_ff;
   assign rsp_chan.payload_high = rsp_hi_ff;
   assign rsp_chan.payload_low  = rsp_lo_ff;
   assign rsp_chan.check_word   = rsp_chk_ff;

endmodule

`default_nettype wire
